FILE: src/fgn_pkg.sv
// Shared constants, tables and register codes of the fractal gradient noise block.
package fgn_pkg;

   localparam int OCTAVE_LANES_DEF = 8;
   localparam int NW = 21;
   localparam int OCT_LAT = 10;

   localparam logic [25:0] FREQ_Q32 = 26'd42949673;
   localparam logic [31:0] GRAD_BIAS = 32'h4000_0000;
   localparam logic signed [20:0] FADE_Q = 21'sd983040;
   localparam logic signed [21:0] FADE_P = 22'sd655360;
   localparam int NOISE_MAX = 524287;
   localparam int NOISE_MIN = -524288;

   localparam logic [31:0] HASH_MUL [2] = '{32'd563, 32'd367};
   localparam int HASH_SHIFT [2] = '{13, 11};
   localparam logic [31:0] HASH_A [2] = '{32'd15731, 32'd20183};
   localparam logic [31:0] HASH_B [2] = '{32'd789221, 32'd815279};

   localparam logic CSR_SEED = 1'b0;
   localparam logic CSR_OCTAVES = 1'b1;

endpackage

FILE: src/fgn_if.sv
// Valid/ready channel interfaces for sample coordinates and noise results.
interface fgn_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;
   modport source (output valid, output coord_x, output coord_y, input ready);
   modport sink (input valid, input coord_x, input coord_y, output ready);
endinterface

interface fgn_rsp_if;
   logic valid;
   logic ready;
   logic signed [19:0] noise_value;
   modport source (output valid, output noise_value, input ready);
   modport sink (input valid, input noise_value, output ready);
endinterface

FILE: src/fgn_octave.sv
// Pipelined gradient noise of one octave: lattice hashes, fade, dot products and blend.
module fgn_octave (
   input  logic                           clock,
   input  logic                           en,
   input  logic [31:0]                    seed,
   input  logic [31:0]                    cell_x,
   input  logic [31:0]                    cell_y,
   input  logic [15:0]                    frac_x,
   input  logic [15:0]                    frac_y,
   output logic signed [fgn_pkg::NW-1:0]  noise
);

   logic [31:0] m1_ff [4][2], m1_in [4][2];
   logic [31:0] m2_ff [4][2], m2_in [4][2];
   logic [31:0] sq_ff [4][2], sq_in [4][2];
   logic [31:0] m2b_ff [4][2];
   logic [31:0] t_ff [4][2], t_in [4][2];
   logic [31:0] m2c_ff [4][2];
   logic [31:0] r_ff [4][2], r_in [4][2];
   logic signed [17:0] g_ff [4][2], g_in [4][2];
   logic signed [34:0] p_ff [4][2], p_in [4][2];
   logic signed [19:0] dot_ff [4], dot_in [4];
   logic signed [fgn_pkg::NW-1:0] e_ff [2], e_in [2];
   logic signed [fgn_pkg::NW-1:0] noise_ff, noise_in;

   logic [15:0] u_ff [6][2];
   logic [15:0] f2_ff [2], f2_in [2];
   logic signed [21:0] pf_ff [2], pf_in [2];
   logic [15:0] f3_ff [2], f3_in [2];
   logic signed [21:0] pf2_ff [2];
   logic [16:0] fd_ff [6][2], fd_in [2];
   logic [16:0] tv_ff;

   function automatic logic [15:0] frac_a(input int a);
      return (a == 0) ? frac_x : frac_y;
   endfunction

   always_comb begin
      logic [1:0] cc;
      logic [31:0] lxc, lyc, h, v;
      logic [31:0] uu, fu;
      logic signed [20:0] q;
      logic signed [37:0] pm;
      logic signed [38:0] fp;
      logic signed [16:0] d;
      logic signed [35:0] ds;
      logic signed [20:0] dif0;
      logic signed [38:0] bp0;
      logic signed [21:0] dif1;
      logic signed [39:0] bp1;
      logic signed [17:0] tu, tv;
      for (int c = 0; c < 4; c++) begin
         cc = 2'(c);
         lxc = cell_x + {31'd0, cc[0]};
         lyc = cell_y + {31'd0, cc[1]};
         for (int j = 0; j < 2; j++) begin
            m1_in[c][j] = lxc + lyc * fgn_pkg::HASH_MUL[j];
            m2_in[c][j] = ((m1_ff[c][j] + seed) << fgn_pkg::HASH_SHIFT[j]) ^ m1_ff[c][j];
            sq_in[c][j] = m2_ff[c][j] * m2_ff[c][j];
            t_in[c][j] = sq_ff[c][j] * fgn_pkg::HASH_A[j] + fgn_pkg::HASH_B[j];
            r_in[c][j] = m2c_ff[c][j] * t_ff[c][j];
            h = r_ff[c][j] + seed;
            v = fgn_pkg::GRAD_BIAS - {1'b0, h[30:0]};
            g_in[c][j] = $signed(v[31:14]);
            d = $signed({cc[j], u_ff[5][j]});
            p_in[c][j] = g_ff[c][j] * d;
         end
         ds = 36'(p_ff[c][0]) + 36'(p_ff[c][1]);
         dot_in[c] = ds[35:16];
      end
      for (int a = 0; a < 2; a++) begin
         uu = {16'd0, frac_a(a)} * {16'd0, frac_a(a)};
         f2_in[a] = uu[31:16];
         q = $signed(21'(6 * {5'd0, frac_a(a)})) - fgn_pkg::FADE_Q;
         pm = $signed({1'b0, frac_a(a)}) * q;
         pf_in[a] = pm[37:16] + fgn_pkg::FADE_P;
         fu = {16'd0, f2_ff[a]} * {16'd0, u_ff[0][a]};
         f3_in[a] = fu[31:16];
         fp = $signed({1'b0, f3_ff[a]}) * pf2_ff[a];
         fd_in[a] = fp[32:16];
      end
      tu = $signed({1'b0, fd_ff[5][0]});
      dif0 = 21'(dot_ff[1]) - 21'(dot_ff[0]);
      bp0 = dif0 * tu;
      e_in[0] = fgn_pkg::NW'(23'(dot_ff[0]) + bp0[38:16]);
      dif0 = 21'(dot_ff[3]) - 21'(dot_ff[2]);
      bp0 = dif0 * tu;
      e_in[1] = fgn_pkg::NW'(23'(dot_ff[2]) + bp0[38:16]);
      tv = $signed({1'b0, tv_ff});
      dif1 = 22'(e_ff[1]) - 22'(e_ff[0]);
      bp1 = dif1 * tv;
      noise_in = fgn_pkg::NW'(24'(e_ff[0]) + bp1[39:16]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         sq_ff <= sq_in;
         m2b_ff <= m2_ff;
         t_ff <= t_in;
         m2c_ff <= m2b_ff;
         r_ff <= r_in;
         g_ff <= g_in;
         p_ff <= p_in;
         dot_ff <= dot_in;
         e_ff <= e_in;
         noise_ff <= noise_in;
         u_ff[0][0] <= frac_x;
         u_ff[0][1] <= frac_y;
         for (int s = 1; s < 6; s++) begin
            u_ff[s] <= u_ff[s-1];
            fd_ff[s] <= fd_ff[s-1];
         end
         f2_ff <= f2_in;
         pf_ff <= pf_in;
         f3_ff <= f3_in;
         pf2_ff <= pf_ff;
         fd_ff[0] <= fd_in;
         tv_ff <= fd_ff[5][1];
      end
   end

   assign noise = noise_ff;

endmodule

FILE: src/fractal_gradient_noise_2d.sv
// Top level of the fractal gradient noise block: octave lanes, weighted sum and division.
//
// The req channel carries one sample coordinate pair (Q16.16) per word; the rsp
// channel returns one Q3.16 noise word for each, in order. Every octave up to
// OCTAVE_LANES has its own pipelined lane, so a new word is taken in every cycle
// in which the pipeline does not hold. Each word passes through the frequency
// multiply register, the octave lanes, the weighted sum and its magnitude, the
// restoring divider by the weight total, which yields the quotient bit by bit,
// and the output register.
// The csr port sets the hash seed (index 0) and the octave count (index 1);
// write it only while no word is in flight.
// Reset is synchronous: it empties the pipeline and restores seed 0 and one
// octave. When the receiver holds rsp ready low with a word waiting, the whole
// pipeline holds and req ready drops; nothing is lost or repeated.
module fractal_gradient_noise_2d #(
   parameter int OCTAVE_LANES = fgn_pkg::OCTAVE_LANES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   fgn_req_if.sink      req,
   fgn_rsp_if.source    rsp,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int NW = fgn_pkg::NW;
   localparam int AW = NW + OCTAVE_LANES;
   localparam int CW = $clog2(OCTAVE_LANES + 1);
   localparam int LAT = 14 + AW;

   logic en;
   logic [LAT-1:0] vld_ff;
   logic [31:0] seed_ff;
   logic [CW-1:0] cnt_ff;

   logic signed [42:0] scx_ff, scy_ff;
   logic signed [58:0] px, py;
   logic signed [NW-1:0] oct_noise [OCTAVE_LANES];

   logic signed [AW-1:0] acc_ff, acc_in;
   logic [OCTAVE_LANES-1:0] wsum;
   logic [OCTAVE_LANES-1:0] rem_ff [AW+1];
   logic [AW-1:0] num_ff [AW+1];
   logic neg_ff [AW+1];
   logic [OCTAVE_LANES-1:0] rem_in [AW+1];
   logic [AW-1:0] num_in [AW+1];
   logic signed [19:0] out_ff, out_in;

   assign en = !rsp.valid || rsp.ready;
   assign req.ready = en;
   assign rsp.valid = vld_ff[LAT-1];
   assign rsp.noise_value = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         cnt_ff <= CW'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            fgn_pkg::CSR_SEED: begin
               seed_ff <= csr_wdata;
            end
            fgn_pkg::CSR_OCTAVES: begin
               if (csr_wdata[3:0] == 4'd0) begin
                  cnt_ff <= CW'(1);
               end else if (int'(csr_wdata[3:0]) > OCTAVE_LANES) begin
                  cnt_ff <= CW'(OCTAVE_LANES);
               end else begin
                  cnt_ff <= CW'(csr_wdata[3:0]);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req.valid};
      end
   end

   assign px = req.coord_x * $signed({1'b0, fgn_pkg::FREQ_Q32});
   assign py = req.coord_y * $signed({1'b0, fgn_pkg::FREQ_Q32});

   always_ff @(posedge clock) begin
      if (en) begin
         scx_ff <= px[58:16];
         scy_ff <= py[58:16];
      end
   end

   for (genvar k = 0; k < OCTAVE_LANES; k++) begin : g_oct
      logic [63:0] skx, sky;
      assign skx = 64'(scx_ff) << k;
      assign sky = 64'(scy_ff) << k;
      fgn_octave u_octave (
         .clock  (clock),
         .en     (en),
         .seed   (seed_ff),
         .cell_x (skx[63:32]),
         .cell_y (sky[63:32]),
         .frac_x (skx[31:16]),
         .frac_y (sky[31:16]),
         .noise  (oct_noise[k])
      );
   end

   always_comb begin
      logic [OCTAVE_LANES:0] full, part;
      acc_in = '0;
      for (int k = 0; k < OCTAVE_LANES; k++) begin
         if (k < int'(cnt_ff)) begin
            acc_in = acc_in + (AW'(oct_noise[k]) <<< (OCTAVE_LANES - 1 - k));
         end
      end
      full = (OCTAVE_LANES + 1)'(1) << OCTAVE_LANES;
      part = (OCTAVE_LANES + 1)'(1) << (OCTAVE_LANES - int'(cnt_ff));
      wsum = OCTAVE_LANES'(full - part);
   end

   always_comb begin
      logic [OCTAVE_LANES:0] rr;
      rem_in[0] = '0;
      num_in[0] = acc_ff[AW-1] ? AW'(-acc_ff) : AW'(acc_ff);
      for (int i = 1; i <= AW; i++) begin
         rr = {rem_ff[i-1], num_ff[i-1][AW-1]};
         if (rr >= {1'b0, wsum}) begin
            rem_in[i] = OCTAVE_LANES'(rr - {1'b0, wsum});
            num_in[i] = {num_ff[i-1][AW-2:0], 1'b1};
         end else begin
            rem_in[i] = OCTAVE_LANES'(rr);
            num_in[i] = {num_ff[i-1][AW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      logic signed [AW:0] qs;
      qs = $signed({1'b0, num_ff[AW]});
      if (neg_ff[AW]) begin
         qs = -qs;
      end
      if (qs > (AW + 1)'(fgn_pkg::NOISE_MAX)) begin
         out_in = 20'(fgn_pkg::NOISE_MAX);
      end else if (qs < (AW + 1)'(fgn_pkg::NOISE_MIN)) begin
         out_in = 20'(fgn_pkg::NOISE_MIN);
      end else begin
         out_in = 20'(qs);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= acc_in;
         rem_ff <= rem_in;
         num_ff <= num_in;
         neg_ff[0] <= acc_ff[AW-1];
         for (int i = 1; i <= AW; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
         out_ff <= out_in;
      end
   end

endmodule
